// ===== rtl/core/nibble_delta_sample_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// nibble_delta_sample_decoder_top_assert.svh
// Assertion macros used by the decoder's parser.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_DELTA_SAMPLE_DECODER_TOP_ASSERT_SVH
`define NIBBLE_DELTA_SAMPLE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define NDSD_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ndsd assertion failed");

// next-cycle implication
`define NDSD_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ndsd assertion failed");

`endif

// ===== rtl/core/ndsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ndsd_pkg
// Shared types, constants and code helpers of the nibble delta decoder.
// ----------------------------------------------------------------------------
package ndsd_pkg;

    localparam int MAX_CHANNELS_DEF = 256;
    localparam int NIB_DEPTH        = 8;
    localparam int QW               = 4 * NIB_DEPTH;
    localparam int QCW              = 4;
    localparam int OUT_DEPTH        = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 9;

    localparam logic [1:0] ACT_DATA        = 2'd0;
    localparam logic [1:0] ACT_BLOCK_START = 2'd1;
    localparam logic [1:0] ACT_MAP_WRITE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE = 2'd1;

    typedef struct packed {
        logic              valid;
        logic              absolute;
        logic              frame_end;
        logic              last;
        logic signed [31:0] delta;
    } code_t;

    typedef struct packed {
        logic [7:0]         pos;
        logic signed [31:0] value;
        logic               frame_end;
        logic               last;
    } result_t;

    typedef struct packed {
        logic clearing;
        logic s1_valid;
        logic s2_valid;
    } pipe_status_t;

    function automatic logic [2:0] code_len(input logic [3:0] head);
        logic [2:0] len;
        if (!head[3])
            len = 3'd1;
        else if (!head[2])
            len = 3'd2;
        else if (!head[1])
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    function automatic logic [31:0] code_delta(input logic [QW-1:0] q, input logic [2:0] len);
        logic [31:0] d;
        case (len)
            3'd1:    d = {{29{q[2]}}, q[2:0]};
            3'd2:    d = {{26{q[1]}}, q[1:0], q[7:4]};
            3'd3:    d = {{23{q[0]}}, q[0], q[7:4], q[11:8]};
            default: d = {{20{q[7]}}, q[7:4], q[11:8], q[15:12]};
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/ndsd_ram.sv =====
// ----------------------------------------------------------------------------
// ndsd_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module ndsd_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 256,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== rtl/core/ndsd_parser.sv =====
// ----------------------------------------------------------------------------
// ndsd_parser
// Nibble queue, code sequencer and channel counter; issues one code a cycle while credit allows.
// ----------------------------------------------------------------------------
`include "nibble_delta_sample_decoder_top_assert.svh"

module ndsd_parser #(
    parameter int  MAX_CHANNELS = ndsd_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  logic [1:0]                         action,
    input  logic [15:0]                        data_word,
    input  logic [ndsd_pkg::CFG_DATA_W-1:0]    num_channels,
    input  logic                               credit,
    output logic                               can_take,
    output ndsd_pkg::code_t                    code,
    output logic [CH_W-1:0]                    ch
);

    import ndsd_pkg::*;

    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam int EW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

    logic [QW-1:0]   q_reg, q_next;
    logic [QCW-1:0]  q_cnt_reg, q_cnt_next;
    logic            active_reg, active_next;
    logic [1:0]      code_idx_reg, code_idx_next;
    logic [CH_W-1:0] ch_cnt_reg, ch_cnt_next;

    logic [2:0]      len, len_nx;
    logic            has_code, issue, more, done;
    logic [QW-1:0]   q_sh, base_q;
    logic [QCW-1:0]  cnt_sh, base_cnt, cnt_sum;
    logic [15:0]     w_vec;
    logic [EW-1:0]   n_eff, num_ext, ch_ext, ch_plus;
    logic [CH_W-1:0] ch_eff;

    always_comb
    begin
        num_ext = EW'(num_channels);
        if (num_ext == '0)
            n_eff = EW'(1);
        else if (num_ext > EW'(MAX_CHANNELS))
            n_eff = EW'(MAX_CHANNELS);
        else
            n_eff = num_ext;

        ch_eff  = (EW'(ch_cnt_reg) >= n_eff) ? '0 : ch_cnt_reg;
        ch_ext  = EW'(ch_eff);
        ch_plus = ch_ext + EW'(1);
    end

    always_comb
    begin
        len      = code_len(q_reg[3:0]);
        has_code = (q_cnt_reg != '0) && (q_cnt_reg >= QCW'(len));
        q_sh     = q_reg >> {len, 2'b00};
        cnt_sh   = q_cnt_reg - QCW'(len);
        len_nx   = code_len(q_sh[3:0]);
        more     = (cnt_sh != '0) && (cnt_sh >= QCW'(len_nx)) && (code_idx_reg != 2'd3);

        issue    = active_reg && has_code && credit;
        done     = active_reg && (!has_code || (issue && !more));
        can_take = !active_reg || done;

        code.valid     = issue;
        code.absolute  = (len == 3'd4);
        code.frame_end = (ch_plus == n_eff);
        code.last      = !more;
        code.delta     = code_delta(q_reg, len);
        ch             = ch_eff;
    end

    always_comb
    begin
        base_q   = issue ? q_sh : q_reg;
        base_cnt = issue ? cnt_sh : q_cnt_reg;
        w_vec    = {data_word[3:0], data_word[7:4], data_word[11:8], data_word[15:12]};
        cnt_sum  = base_cnt + QCW'(4);

        q_next        = base_q;
        q_cnt_next    = base_cnt;
        active_next   = active_reg && !done;
        code_idx_next = issue ? code_idx_reg + 2'd1 : code_idx_reg;
        ch_cnt_next   = ch_cnt_reg;

        if (issue)
        begin
            ch_cnt_next = (ch_plus >= n_eff) ? '0 : ch_plus[CH_W-1:0];
        end

        if (take)
        begin
            case (action)
                ACT_DATA:
                begin
                    q_next        = base_q | (QW'(w_vec) << {base_cnt, 2'b00});
                    q_cnt_next    = (cnt_sum > QCW'(NIB_DEPTH)) ? QCW'(NIB_DEPTH) : cnt_sum;
                    active_next   = 1'b1;
                    code_idx_next = '0;
                end
                ACT_BLOCK_START:
                begin
                    q_next      = '0;
                    q_cnt_next  = '0;
                    ch_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg        <= '0;
            q_cnt_reg    <= '0;
            active_reg   <= 1'b0;
            code_idx_reg <= '0;
            ch_cnt_reg   <= '0;
        end
        else
        begin
            q_reg        <= q_next;
            q_cnt_reg    <= q_cnt_next;
            active_reg   <= active_next;
            code_idx_reg <= code_idx_next;
            ch_cnt_reg   <= ch_cnt_next;
        end
    end

    `NDSD_ASSERT_IMP(a_fourth_code_last, clk, rst_n, issue && (code_idx_reg == 2'd3), code.last)
    `NDSD_ASSERT_IMP(a_take_only_when_done, clk, rst_n, take && active_reg, done)
    `NDSD_ASSERT_NXT(a_data_starts_decode, clk, rst_n, take && (action == ACT_DATA), active_reg)
    `NDSD_ASSERT_IMP(a_empty_only_first, clk, rst_n, active_reg && !has_code, code_idx_reg == 2'd0)

endmodule

// ===== rtl/core/ndsd_acc_pipe.sv =====
// ----------------------------------------------------------------------------
// ndsd_acc_pipe
// Remap lookup and accumulator read-modify-write pipeline with forwarding;
// clears the accumulator store after reset.
// ----------------------------------------------------------------------------
module ndsd_acc_pipe #(
    parameter int  MAX_CHANNELS = ndsd_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ndsd_pkg::code_t        code,
    input  logic [CH_W-1:0]        ch,
    input  logic                   remap_enable,
    input  logic                   map_we,
    input  logic [7:0]             map_index,
    input  logic [7:0]             map_value,
    output ndsd_pkg::pipe_status_t status,
    output logic                   res_valid,
    output ndsd_pkg::result_t      res
);

    import ndsd_pkg::*;

    localparam int ACC_DEPTH = (MAX_CHANNELS > 256) ? MAX_CHANNELS : 256;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);

    logic [CH_W+7:0]    ch_wide;
    logic [7:0]         remap_raddr, remap_rdata;

    logic               s1_valid_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    logic [31:0]        s1_delta_reg;
    logic               s1_abs_reg, s1_fe_reg, s1_last_reg;
    logic [ACC_AW-1:0]  s1_pos;

    logic               s2_valid_reg;
    logic [ACC_AW-1:0]  s2_pos_reg;
    logic [31:0]        s2_delta_reg;
    logic               s2_abs_reg, s2_fe_reg, s2_last_reg;

    logic               fwd_valid_reg;
    logic [ACC_AW-1:0]  fwd_pos_reg;
    logic [31:0]        fwd_val_reg;

    logic               clr_active_reg, clr_active_next;
    logic [ACC_AW-1:0]  clr_addr_reg, clr_addr_next;

    logic [31:0]        acc_rdata, acc_base, acc_new, acc_wdata;
    logic [ACC_AW-1:0]  acc_waddr;
    logic               acc_we;

    assign ch_wide     = {8'd0, ch};
    assign remap_raddr = ch_wide[7:0];

    ndsd_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_remap_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_index),
        .wdata (map_value),
        .raddr (remap_raddr),
        .rdata (remap_rdata)
    );

    assign s1_pos = remap_enable ? ACC_AW'(remap_rdata) : ACC_AW'(s1_ch_reg);

    ndsd_ram #(
        .WIDTH (32),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (s1_pos),
        .rdata (acc_rdata)
    );

    always_comb
    begin
        acc_base = (fwd_valid_reg && (fwd_pos_reg == s2_pos_reg)) ? fwd_val_reg : acc_rdata;
        acc_new  = s2_abs_reg ? s2_delta_reg : acc_base + s2_delta_reg;

        acc_we    = clr_active_reg || s2_valid_reg;
        acc_waddr = clr_active_reg ? clr_addr_reg : s2_pos_reg;
        acc_wdata = clr_active_reg ? '0 : acc_new;

        clr_active_next = clr_active_reg && (clr_addr_reg != ACC_AW'(ACC_DEPTH - 1));
        clr_addr_next   = clr_active_reg ? clr_addr_reg + ACC_AW'(1) : clr_addr_reg;

        res_valid     = s2_valid_reg;
        res.pos       = s2_pos_reg[7:0];
        res.value     = acc_new;
        res.frame_end = s2_fe_reg;
        res.last      = s2_last_reg;

        status.clearing = clr_active_reg;
        status.s1_valid = s1_valid_reg;
        status.s2_valid = s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= code.valid;
            s2_valid_reg   <= s1_valid_reg;
            fwd_valid_reg  <= s2_valid_reg;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg    <= ch;
        s1_delta_reg <= code.delta;
        s1_abs_reg   <= code.absolute;
        s1_fe_reg    <= code.frame_end;
        s1_last_reg  <= code.last;

        s2_pos_reg   <= s1_pos;
        s2_delta_reg <= s1_delta_reg;
        s2_abs_reg   <= s1_abs_reg;
        s2_fe_reg    <= s1_fe_reg;
        s2_last_reg  <= s1_last_reg;

        fwd_pos_reg  <= s2_pos_reg;
        fwd_val_reg  <= acc_new;
    end

endmodule

// ===== rtl/core/ndsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// ndsd_out_buf
// Small result queue between the accumulator pipeline and the output port.
// ----------------------------------------------------------------------------
module ndsd_out_buf (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    input  ndsd_pkg::result_t                        push_data,
    input  logic                                     pop,
    output logic                                     head_valid,
    output ndsd_pkg::result_t                        head,
    output logic [$clog2(ndsd_pkg::OUT_DEPTH+1)-1:0] count
);

    import ndsd_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    result_t        mem [OUT_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
        head_valid  = (cnt_reg != '0);
        head        = mem[rd_ptr_reg];
        count       = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/nibble_delta_sample_decoder_top.sv =====
// A code is issued from the registered nibble queue once the word that completes it is taken; it then
// passes the s1 and s2 pipeline registers and the output queue before it appears as a result.
// One result per cycle while credit allows and out_stall is low; a data word holds the input until the
// decode sequencer, issuing one code per cycle into the accumulator RAM pipeline, has issued its codes.
// Reset: the accumulator RAM is swept to zero, all max(MAX_CHANNELS, 256) entries, with in_stall high.
// ----------------------------------------------------------------------------
// nibble_delta_sample_decoder_top
// Variable-length nibble delta decoder with per-channel accumulators.
// ----------------------------------------------------------------------------
module nibble_delta_sample_decoder_top #(
    parameter int MAX_CHANNELS = ndsd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic [15:0]                       data_word,
    input  logic [7:0]                        map_index,
    input  logic [7:0]                        map_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        channel_pos,
    output logic signed [31:0]                sample_value,
    output logic                              frame_end,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ndsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ndsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ndsd_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW   = $clog2(OUT_DEPTH + 1);

    logic [CFG_DATA_W-1:0] num_channels_reg;
    logic                  remap_enable_reg;

    logic                  take, can_take, credit, map_we, pop;
    code_t                 code;
    logic [CH_W-1:0]       ch;
    pipe_status_t          status;
    logic                  res_valid;
    result_t               res, head;
    logic [CW-1:0]         buf_count;
    logic [CW:0]           pending;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= CFG_DATA_W'(1);
            remap_enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_CHANNELS: num_channels_reg <= cfg_data;
                CFG_REMAP_ENABLE: remap_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = status.clearing || !can_take;
    assign take     = in_valid && !in_stall;
    assign map_we   = take && (action == ACT_MAP_WRITE);

    // worst case: everything in flight lands before the queue drains
    assign pending  = (CW+1)'(buf_count) + (CW+1)'(status.s1_valid) + (CW+1)'(status.s2_valid);
    assign credit   = pending < (CW+1)'(OUT_DEPTH);

    ndsd_parser #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .action       (action),
        .data_word    (data_word),
        .num_channels (num_channels_reg),
        .credit       (credit),
        .can_take     (can_take),
        .code         (code),
        .ch           (ch)
    );

    ndsd_acc_pipe #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_acc_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .code         (code),
        .ch           (ch),
        .remap_enable (remap_enable_reg),
        .map_we       (map_we),
        .map_index    (map_index),
        .map_value    (map_value),
        .status       (status),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign pop = out_valid && !out_stall;

    ndsd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .head_valid (out_valid),
        .head       (head),
        .count      (buf_count)
    );

    assign channel_pos  = head.pos;
    assign sample_value = head.value;
    assign frame_end    = head.frame_end;
    assign last         = head.last;

endmodule
